// ===== rtl/erc_pkg.sv =====
// erc_pkg: shared types and constants for the element rank counter.
// No dependencies; imported by every module of the block.
package erc_pkg;

  localparam int VALUE_W = 32;
  localparam int RANK_W  = 6;

  typedef enum logic [2:0] {
    S_LOAD,
    S_KEY,
    S_LATCH,
    S_SCAN,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic acc;
  } rank_ctl_t;

endpackage

// ===== rtl/erc_store.sv =====
// erc_store: value memory, one write port, one registered read port.
// Depends on erc_pkg for the word width.
module erc_store #(
  parameter int DEPTH  = 32,
  parameter int ADDR_W = 5
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [ADDR_W-1:0]          wr_addr,
  input  logic [erc_pkg::VALUE_W-1:0] wr_data,
  input  logic [ADDR_W-1:0]          rd_addr,
  output logic [erc_pkg::VALUE_W-1:0] rd_data
);
  import erc_pkg::*;

  logic [VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/erc_rank_unit.sv =====
// erc_rank_unit: shared signed comparator and rank accumulator.
// Depends on erc_pkg for the control struct and word width.
module erc_rank_unit #(
  parameter int ACC_W = 5
) (
  input  logic                        clk,
  input  erc_pkg::rank_ctl_t          ctl,
  input  logic [erc_pkg::VALUE_W-1:0] data,
  output logic [ACC_W-1:0]            acc
);
  import erc_pkg::*;

  logic [VALUE_W-1:0] key;
  logic               less;

  assign less = $signed(data) < $signed(key);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      key <= data;
      acc <= '0;
    end else if (ctl.acc && less) begin
      acc <= acc + ACC_W'(1);
    end
  end

endmodule

// ===== rtl/element_rank_counter.sv =====
// element_rank_counter: loads a set of signed words, then gives each one's rank.
// Load: one input word per cycle; the word marked last starts rank output.
// Rank: each result takes one pass of the shared comparator over
// the n stored words through the single memory read port.
// Reset (rst, synchronous) empties the set and clears the overflow flag.
module element_rank_counter #(
  parameter int MAX_COUNT = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [erc_pkg::VALUE_W-1:0] value,
  input  logic                        last,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [erc_pkg::RANK_W-1:0]  rank,
  output logic                        final_res,
  output logic                        overflow
);
  import erc_pkg::*;

  localparam int CNT_W = $clog2(MAX_COUNT + 1);
  localparam int IDX_W = $clog2(MAX_COUNT);

  state_t             state, state_next;
  logic [CNT_W-1:0]   count, count_next;
  logic               ovf, ovf_next;
  logic [IDX_W-1:0]   i, i_next;
  logic [CNT_W-1:0]   j, j_next;
  logic               wr_en;
  logic [IDX_W-1:0]   rd_addr;
  logic [VALUE_W-1:0] rd_data;
  logic [IDX_W-1:0]   acc;
  rank_ctl_t          ctl;

  erc_store #(
    .DEPTH  (MAX_COUNT),
    .ADDR_W (IDX_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count[IDX_W-1:0]),
    .wr_data (value),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  erc_rank_unit #(
    .ACC_W (IDX_W)
  ) u_rank (
    .clk  (clk),
    .ctl  (ctl),
    .data (rd_data),
    .acc  (acc)
  );

  assign rank      = RANK_W'(acc);
  assign final_res = (CNT_W'(i) + CNT_W'(1)) == count;
  assign overflow  = ovf;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ovf   <= 1'b0;
      i     <= '0;
      j     <= '0;
    end else begin
      count <= count_next;
      ovf   <= ovf_next;
      i     <= i_next;
      j     <= j_next;
    end
  end

  always_comb begin
    state_next = state;
    count_next = count;
    ovf_next   = ovf;
    i_next     = i;
    j_next     = j;
    wr_en      = 1'b0;
    rd_addr    = i;
    ctl        = '0;
    in_stall   = 1'b1;
    out_valid  = 1'b0;
    case (state)
      S_LOAD: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (count < CNT_W'(MAX_COUNT)) begin
            wr_en      = 1'b1;
            count_next = count + CNT_W'(1);
          end else begin
            ovf_next = 1'b1;
          end
          if (last) begin
            i_next     = '0;
            state_next = S_KEY;
          end
        end
      end
      S_KEY: begin
        rd_addr    = i;
        state_next = S_LATCH;
      end
      S_LATCH: begin
        ctl.load   = 1'b1;
        rd_addr    = '0;
        j_next     = CNT_W'(1);
        state_next = S_SCAN;
      end
      S_SCAN: begin
        ctl.acc = 1'b1;
        if (j == count) begin
          state_next = S_EMIT;
        end else begin
          rd_addr = j[IDX_W-1:0];
          j_next  = j + CNT_W'(1);
        end
      end
      S_EMIT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          if (final_res) begin
            count_next = '0;
            ovf_next   = 1'b0;
            state_next = S_LOAD;
          end else begin
            i_next     = i + IDX_W'(1);
            state_next = S_KEY;
          end
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_COUNT))
    else $error("stored count above capacity");

  a_drop_sets_ovf: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && count == CNT_W'(MAX_COUNT)) |=> ovf)
    else $error("dropped word did not raise overflow");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (count != '0 && CNT_W'(i) < count))
    else $error("result for an empty slot");

  a_rank_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> CNT_W'(acc) < count)
    else $error("rank not below set size");

  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && final_res) |=> (count == '0 && !ovf && !in_stall))
    else $error("set not cleared after final result");

endmodule
